FILE: hdl/cubic_hermite_vertex_interp_unit_defines.svh
// Assertion macros shared by the cubic Hermite vertex interpolator RTL
`ifndef CUBIC_HERMITE_VERTEX_INTERP_UNIT_DEFINES_SVH
`define CUBIC_HERMITE_VERTEX_INTERP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CHVI_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("chvi assertion failed");
`define CHVI_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("chvi assertion failed");
`else
`define CHVI_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define CHVI_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

FILE: hdl/chvi_pkg.sv
// Types, constants and rounding helpers of the cubic Hermite vertex interpolator
package chvi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NSTAGE        = 8;
  localparam int COEF_ST       = 3;
  localparam int U_W           = 17;
  localparam logic [U_W-1:0] U_ONE = 17'h10000;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 25;
  localparam int RATE_W        = 16;
  localparam int PERIOD_W      = 25;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERP_PARAM = 2'd0,
    CFG_FRAME_RATE   = 2'd1,
    CFG_FRAME_PERIOD = 2'd2,
    CFG_BYPASS       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos0_x;
    logic signed [31:0] pos0_y;
    logic signed [31:0] pos0_z;
    logic signed [31:0] pos1_x;
    logic signed [31:0] pos1_y;
    logic signed [31:0] pos1_z;
    logic signed [31:0] vel0_x;
    logic signed [31:0] vel0_y;
    logic signed [31:0] vel0_z;
    logic signed [31:0] vel1_x;
    logic signed [31:0] vel1_y;
    logic signed [31:0] vel1_z;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [31:0] value;
    logic        clamp;
  } sat_t;

  // round v / 2^s to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int unsigned s);
    logic signed [63:0] half;
    logic signed [63:0] bias;
    half = 64'sd1 <<< (s - 1);
    bias = half - (v[63] ? 64'sd1 : 64'sd0);
    return (v + bias) >>> s;
  endfunction

  function automatic sat_t sat32(logic signed [63:0] v);
    sat_t r;
    if (v > S32_MAX) begin
      r.value = 32'h7fff_ffff;
      r.clamp = 1'b1;
    end else if (v < S32_MIN) begin
      r.value = 32'h8000_0000;
      r.clamp = 1'b1;
    end else begin
      r.value = v[31:0];
      r.clamp = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/chvi_ifs.sv
// Valid/ready channel interfaces for vertex beats and result beats
interface chvi_vertex_if import chvi_pkg::*; ();
  logic    valid;
  logic    ready;
  vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface chvi_result_if import chvi_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/chvi_coef.sv
// Hermite basis coefficient pipeline driven by the interpolation parameter
module chvi_coef import chvi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [COEF_ST-1:0]          adv,
  input  logic [U_W-1:0]              interp_param,
  output logic [FRAC_BITS:0]          ca,
  output logic [FRAC_BITS:0]          cb,
  output logic [FRAC_BITS:0]          cc,
  output logic [FRAC_BITS:0]          cd,
  output logic [FRAC_BITS:0]          va,
  output logic signed [FRAC_BITS+1:0] vb,
  output logic signed [FRAC_BITS+1:0] vc
);

  logic [U_W-1:0]          u_c;
  logic [U_W-1:0]          w_c;
  logic [U_W+1:0]          u3;
  logic signed [U_W+1:0]   m3;
  logic signed [U_W+1:0]   n3;
  logic signed [U_W:0]     u_s;
  logic signed [U_W:0]     w_s;

  logic [U_W-1:0]          u1;
  logic [U_W-1:0]          w1;
  logic [2*U_W-1:0]        uu1;
  logic [2*U_W-1:0]        uw1;
  logic [2*U_W-1:0]        ww1;
  logic signed [2*U_W+2:0] vb1;
  logic signed [2*U_W+2:0] vc1;

  logic [U_W:0]            p2;
  logic [U_W:0]            q2;
  logic signed [63:0]      rvb;
  logic signed [63:0]      rvc;

  logic [3*U_W:0]          ca2;
  logic [3*U_W-1:0]        cb2;
  logic [3*U_W-1:0]        cc2;
  logic [3*U_W:0]          cd2;
  logic [2*U_W+2:0]        va2;
  logic signed [FRAC_BITS+1:0] vb2;
  logic signed [FRAC_BITS+1:0] vc2;

  logic signed [63:0]      rca;
  logic signed [63:0]      rcb;
  logic signed [63:0]      rcc;
  logic signed [63:0]      rcd;
  logic signed [63:0]      rva;

  always_comb begin
    u_c = (interp_param > U_ONE) ? U_ONE : interp_param;
    w_c = U_ONE - u_c;
    u3  = {1'b0, u_c, 1'b0} + {2'b00, u_c};
    m3  = {2'b00, U_ONE} - u3;
    n3  = u3 - {1'b0, U_ONE, 1'b0};
    u_s = {1'b0, u_c};
    w_s = {1'b0, w_c};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      u1  <= u_c;
      w1  <= w_c;
      uu1 <= (2*U_W)'(u_c) * (2*U_W)'(u_c);
      uw1 <= (2*U_W)'(u_c) * (2*U_W)'(w_c);
      ww1 <= (2*U_W)'(w_c) * (2*U_W)'(w_c);
      vb1 <= (2*U_W+3)'(w_s) * (2*U_W+3)'(m3);
      vc1 <= (2*U_W+3)'(u_s) * (2*U_W+3)'(n3);
    end
  end

  always_comb begin
    p2  = {1'b0, U_ONE} + {u1, 1'b0};
    q2  = {U_ONE, 1'b0} + {1'b0, U_ONE} - {u1, 1'b0};
    rvb = rnd_shr(64'(vb1), 32 - FRAC_BITS);
    rvc = rnd_shr(64'(vc1), 32 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ca2 <= (3*U_W+1)'(ww1) * (3*U_W+1)'(p2);
      cb2 <= (3*U_W)'(uw1) * (3*U_W)'(w1);
      cc2 <= (3*U_W)'(uu1) * (3*U_W)'(w1);
      cd2 <= (3*U_W+1)'(uu1) * (3*U_W+1)'(q2);
      va2 <= {1'b0, uw1, 2'b00} + {2'b00, uw1, 1'b0};
      vb2 <= rvb[FRAC_BITS+1:0];
      vc2 <= rvc[FRAC_BITS+1:0];
    end
  end

  always_comb begin
    rca = rnd_shr(64'(ca2), 48 - FRAC_BITS);
    rcb = rnd_shr(64'(cb2), 48 - FRAC_BITS);
    rcc = rnd_shr(64'(cc2), 48 - FRAC_BITS);
    rcd = rnd_shr(64'(cd2), 48 - FRAC_BITS);
    rva = rnd_shr(64'(va2), 32 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ca <= rca[FRAC_BITS:0];
      cb <= rcb[FRAC_BITS:0];
      cc <= rcc[FRAC_BITS:0];
      cd <= rcd[FRAC_BITS:0];
      va <= rva[FRAC_BITS:0];
      vb <= vb2;
      vc <= vc2;
    end
  end

endmodule

FILE: hdl/chvi_lane.sv
// One-axis datapath: velocity scaling, basis products, sums, rounding, clamping
module chvi_lane import chvi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [NSTAGE-1:0]           adv,
  input  logic signed [31:0]          pos0,
  input  logic signed [31:0]          pos1,
  input  logic signed [31:0]          vel0,
  input  logic signed [31:0]          vel1,
  input  logic [FRAC_BITS:0]          ca,
  input  logic [FRAC_BITS:0]          cb,
  input  logic [FRAC_BITS:0]          cc,
  input  logic [FRAC_BITS:0]          cd,
  input  logic [FRAC_BITS:0]          va,
  input  logic signed [FRAC_BITS+1:0] vb,
  input  logic signed [FRAC_BITS+1:0] vc,
  input  logic [PERIOD_W-1:0]         frame_period,
  input  logic [RATE_W-1:0]           frame_rate,
  input  logic                        bypass,
  output logic signed [31:0]          pos,
  output logic signed [31:0]          vel,
  output logic                        clamp
);

  localparam int VP_W  = 32 + PERIOD_W + 1;
  localparam int PR_W  = FRAC_BITS + 35;
  localparam int SUM_W = FRAC_BITS + 37;
  localparam int VF_W  = 37;
  localparam int FV_W  = VF_W + RATE_W + 1;

  logic signed [PERIOD_W:0]    per_s;
  logic signed [RATE_W:0]      fps_s;
  logic signed [FRAC_BITS+1:0] ca_s;
  logic signed [FRAC_BITS+1:0] cb_s;
  logic signed [FRAC_BITS+1:0] cc_s;
  logic signed [FRAC_BITS+1:0] cd_s;
  logic signed [FRAC_BITS+1:0] va_s;

  logic signed [31:0] p0_q [NSTAGE-1];
  logic signed [31:0] v0_q [NSTAGE-1];

  logic signed [VP_W-1:0]  v0p1;
  logic signed [VP_W-1:0]  v1p1;
  logic signed [31:0]      p1_1;
  logic signed [63:0]      r0;
  logic signed [63:0]      r1;

  logic signed [32:0]      v0f2;
  logic signed [32:0]      v1f2;
  logic signed [32:0]      diff2;
  logic signed [31:0]      p1_2;

  logic signed [32:0]      v0f3;
  logic signed [32:0]      v1f3;
  logic signed [32:0]      diff3;
  logic signed [31:0]      p1_3;

  logic signed [PR_W-1:0]  tpa;
  logic signed [PR_W-1:0]  tpb;
  logic signed [PR_W-1:0]  tpc;
  logic signed [PR_W-1:0]  tpd;
  logic signed [PR_W-1:0]  tva;
  logic signed [PR_W-1:0]  tvb;
  logic signed [PR_W-1:0]  tvc;

  logic signed [SUM_W-1:0] pos_sum;
  logic signed [SUM_W-1:0] vel_sum;
  logic signed [63:0]      rpos;
  logic signed [63:0]      rvf;
  sat_t                    spos;

  logic signed [31:0]      pos6;
  logic                    pclamp6;
  logic signed [VF_W-1:0]  vf6;

  logic signed [31:0]      pos7;
  logic                    pclamp7;
  logic signed [FV_W-1:0]  velp7;
  logic signed [63:0]      rvel;
  sat_t                    svel;

  always_comb begin
    per_s = {1'b0, frame_period};
    fps_s = {1'b0, frame_rate};
    ca_s  = {1'b0, ca};
    cb_s  = {1'b0, cb};
    cc_s  = {1'b0, cc};
    cd_s  = {1'b0, cd};
    va_s  = {1'b0, va};
  end

  // raw p0 and v0 ride along for the pass-through case
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_q[0] <= pos0;
      v0_q[0] <= vel0;
    end
    for (int k = 1; k < NSTAGE - 1; k++) begin
      if (adv[k]) begin
        p0_q[k] <= p0_q[k-1];
        v0_q[k] <= v0_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      v0p1 <= VP_W'(vel0) * VP_W'(per_s);
      v1p1 <= VP_W'(vel1) * VP_W'(per_s);
      p1_1 <= pos1;
    end
  end

  always_comb begin
    r0 = rnd_shr(64'(v0p1), 24);
    r1 = rnd_shr(64'(v1p1), 24);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      v0f2  <= r0[32:0];
      v1f2  <= r1[32:0];
      diff2 <= 33'(p1_1) - 33'(p0_q[0]);
      p1_2  <= p1_1;
    end
    if (adv[2]) begin
      v0f3  <= v0f2;
      v1f3  <= v1f2;
      diff3 <= diff2;
      p1_3  <= p1_2;
    end
    if (adv[3]) begin
      tpa <= PR_W'(ca_s) * PR_W'(p0_q[2]);
      tpb <= PR_W'(cb_s) * PR_W'(v0f3);
      tpc <= PR_W'(cc_s) * PR_W'(v1f3);
      tpd <= PR_W'(cd_s) * PR_W'(p1_3);
      tva <= PR_W'(va_s) * PR_W'(diff3);
      tvb <= PR_W'(vb) * PR_W'(v0f3);
      tvc <= PR_W'(vc) * PR_W'(v1f3);
    end
    if (adv[4]) begin
      pos_sum <= SUM_W'(tpa) + SUM_W'(tpb) - SUM_W'(tpc) + SUM_W'(tpd);
      vel_sum <= SUM_W'(tva) + SUM_W'(tvb) + SUM_W'(tvc);
    end
  end

  always_comb begin
    rpos = rnd_shr(64'(pos_sum), FRAC_BITS);
    rvf  = rnd_shr(64'(vel_sum), FRAC_BITS);
    spos = sat32(rpos);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      pos6    <= spos.value;
      pclamp6 <= spos.clamp;
      vf6     <= rvf[VF_W-1:0];
    end
    if (adv[6]) begin
      pos7    <= pos6;
      pclamp7 <= pclamp6;
      velp7   <= FV_W'(vf6) * FV_W'(fps_s);
    end
  end

  always_comb begin
    rvel = rnd_shr(64'(velp7), 8);
    svel = sat32(rvel);
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      if (bypass) begin
        pos   <= p0_q[6];
        vel   <= v0_q[6];
        clamp <= 1'b0;
      end else begin
        pos   <= pos7;
        vel   <= svel.value;
        clamp <= pclamp7 | svel.clamp;
      end
    end
  end

endmodule

FILE: hdl/cubic_hermite_vertex_interp_unit.sv
// Top level of the cubic Hermite vertex interpolator: config registers and pipeline control
//
//   channel   dir   handshake        beat
//   vertex    in    valid / ready    p0, p1, v0, v1 (xyz, Q16.16)
//   result    out   valid / ready    position, velocity (xyz, Q16.16), saturated
//   cfg_wr    in    cfg_wr_en        cfg_wr_index, cfg_wr_data
//
// One vertex per cycle sustained while result ready holds; the 8-stage multiply/round pipeline
// carries each accepted beat through its stage registers into the result register.
// Every stage carries a valid bit and advances when it is empty or the stage after it
// advances, so bubbles close up; a stalled result holds the full stages behind it, and
// vertex ready drops only when all 8 stages are full and the result is stalled.
// rst clears the valid bits and loads the register defaults.
`include "cubic_hermite_vertex_interp_unit_defines.svh"

module cubic_hermite_vertex_interp_unit import chvi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  chvi_vertex_if.sink           vertex,
  chvi_result_if.source         result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int MID = NSTAGE / 2;

  logic [U_W-1:0]      interp_param;
  logic [RATE_W-1:0]   frame_rate;
  logic [PERIOD_W-1:0] frame_period;
  logic                bypass;

  logic [NSTAGE-1:0]   v;
  logic [NSTAGE-1:0]   adv;

  logic [FRAC_BITS:0]          ca;
  logic [FRAC_BITS:0]          cb;
  logic [FRAC_BITS:0]          cc;
  logic [FRAC_BITS:0]          cd;
  logic [FRAC_BITS:0]          va;
  logic signed [FRAC_BITS+1:0] vb;
  logic signed [FRAC_BITS+1:0] vc;

  logic clamp_x;
  logic clamp_y;
  logic clamp_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_param <= '0;
      frame_rate   <= 16'd6144;
      frame_period <= 25'd699051;
      bypass       <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_wr_index))
        CFG_INTERP_PARAM: interp_param <= cfg_wr_data[U_W-1:0];
        CFG_FRAME_RATE:   frame_rate   <= cfg_wr_data[RATE_W-1:0];
        CFG_FRAME_PERIOD: frame_period <= cfg_wr_data[PERIOD_W-1:0];
        CFG_BYPASS:       bypass       <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    adv[NSTAGE-1] = !v[NSTAGE-1] || result.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= vertex.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign vertex.ready = adv[0];
  assign result.valid = v[NSTAGE-1];

  chvi_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk          (clk),
    .adv          (adv[COEF_ST-1:0]),
    .interp_param (interp_param),
    .ca           (ca),
    .cb           (cb),
    .cc           (cc),
    .cd           (cd),
    .va           (va),
    .vb           (vb),
    .vc           (vc)
  );

  chvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk          (clk),
    .adv          (adv),
    .pos0         (vertex.data.pos0_x),
    .pos1         (vertex.data.pos1_x),
    .vel0         (vertex.data.vel0_x),
    .vel1         (vertex.data.vel1_x),
    .ca           (ca),
    .cb           (cb),
    .cc           (cc),
    .cd           (cd),
    .va           (va),
    .vb           (vb),
    .vc           (vc),
    .frame_period (frame_period),
    .frame_rate   (frame_rate),
    .bypass       (bypass),
    .pos          (result.data.out_pos_x),
    .vel          (result.data.out_vel_x),
    .clamp        (clamp_x)
  );

  chvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk          (clk),
    .adv          (adv),
    .pos0         (vertex.data.pos0_y),
    .pos1         (vertex.data.pos1_y),
    .vel0         (vertex.data.vel0_y),
    .vel1         (vertex.data.vel1_y),
    .ca           (ca),
    .cb           (cb),
    .cc           (cc),
    .cd           (cd),
    .va           (va),
    .vb           (vb),
    .vc           (vc),
    .frame_period (frame_period),
    .frame_rate   (frame_rate),
    .bypass       (bypass),
    .pos          (result.data.out_pos_y),
    .vel          (result.data.out_vel_y),
    .clamp        (clamp_y)
  );

  chvi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk          (clk),
    .adv          (adv),
    .pos0         (vertex.data.pos0_z),
    .pos1         (vertex.data.pos1_z),
    .vel0         (vertex.data.vel0_z),
    .vel1         (vertex.data.vel1_z),
    .ca           (ca),
    .cb           (cb),
    .cc           (cc),
    .cd           (cd),
    .va           (va),
    .vb           (vb),
    .vc           (vc),
    .frame_period (frame_period),
    .frame_rate   (frame_rate),
    .bypass       (bypass),
    .pos          (result.data.out_pos_z),
    .vel          (result.data.out_vel_z),
    .clamp        (clamp_z)
  );

  assign result.data.saturated = clamp_x | clamp_y | clamp_z;

  `CHVI_ASSERT_NXT(a_fill_up, clk, rst, vertex.valid && vertex.ready && !(result.valid && result.ready), $countones(v) == $past($countones(v)) + 1)
  `CHVI_ASSERT_NXT(a_drain, clk, rst, !(vertex.valid && vertex.ready) && result.valid && result.ready, $countones(v) + 1 == $past($countones(v)))
  `CHVI_ASSERT_NXT(a_mid_hold, clk, rst, v[MID] && !adv[MID], v[MID])
  `CHVI_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), v == '0)

endmodule
